// File: rtl/jdqt_pkg.sv
// Shared types and constants for the JPEG marker and DQT parser.
`timescale 1ns / 1ps

package jdqt_pkg;

    // Fixed geometry of a quantization table and of the stream fields
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = 6;
    localparam int ID_W          = 4;
    localparam int VAL_W         = 16;
    localparam int TDATA_OUT_W   = 32;

    // Marker codes, last entry index and segment length constants
    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] MARKER_SOI    = 8'hD8;
    localparam logic [7:0] MARKER_DQT    = 8'hDB;
    localparam logic [7:0] MARKER_APP0   = 8'hE0;
    localparam logic [7:0] MARKER_APP15  = 8'hEF;
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [15:0] NEED_NARROW  = 16'(TABLE_ENTRIES);
    localparam logic [15:0] NEED_WIDE    = 16'(2 * TABLE_ENTRIES);
    localparam logic [15:0] LEN_HEADER   = 16'd2;

    typedef enum logic [3:0] {
        PH_SOI0       = 4'd0,
        PH_SOI1       = 4'd1,
        PH_MARK0      = 4'd2,
        PH_MARK1      = 4'd3,
        PH_DQT_LEN_HI = 4'd4,
        PH_DQT_LEN_LO = 4'd5,
        PH_DQT_INFO   = 4'd6,
        PH_ENTRY_HI   = 4'd7,
        PH_ENTRY_LO   = 4'd8,
        PH_APP_LEN_HI = 4'd9,
        PH_APP_LEN_LO = 4'd10,
        PH_APP_SKIP   = 4'd11
    } t_phase;

    typedef enum logic [2:0] {
        EV_ENTRY     = 3'd0,
        EV_NO_SOI    = 3'd1,
        EV_NO_MARKER = 3'd2,
        EV_BAD_ID    = 3'd3,
        EV_BAD_LEN   = 3'd4,
        EV_EARLY_END = 3'd5
    } t_event;

    typedef struct packed {
        t_event           event_res;
        logic [1:0]       table_id;
        logic [IDX_W-1:0] entry_index;
        logic [VAL_W-1:0] entry_value;
        logic             wide_entries;
        logic             last_in_table;
    } t_result;

    typedef struct packed {
        logic             en;
        logic [ID_W-1:0]  table_sel;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
    } t_wr;

    typedef struct packed {
        logic   halted;
        t_phase phase;
    } t_status;

endpackage

// File: rtl/jpeg_marker_and_dqt_parser_top.sv
// Top level: JPEG marker scanner and DQT loader with stream ports and table RAM.
// Path: an accepted byte is held in the input register, its result beat in the result register.
// Throughput: one byte per cycle; a byte with a result waits in the input register
// only while the result register is full and not being taken.
// Reset: synchronous, active low; clears phase, counters, halt flag and beat valids.
// The table RAM is not cleared; its contents are undefined until written.
`timescale 1ns / 1ps

module jpeg_marker_and_dqt_parser_top #(
    parameter int TABLE_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // end_of_stream
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [2:0] event_res, [4:3] table_id, [10:5] entry_index,
                                     // [26:11] entry_value, [27] wide_entries, [31:28] zero
    output logic        o_m_tlast    // last_in_table
);

    localparam int DEPTH  = TABLE_COUNT * jdqt_pkg::TABLE_ENTRIES;
    localparam int ADDR_W = $clog2(DEPTH);

    // Input register: holds one byte; doubles as the skid stage when the
    // result register is blocked.
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_eos;

    // Result register
    logic              r_out_valid;
    jdqt_pkg::t_result r_out;

    logic              take;
    logic              emit;
    logic              out_free;
    logic              res_load;
    logic              s_accept;
    jdqt_pkg::t_result res;
    jdqt_pkg::t_wr     wr;
    jdqt_pkg::t_status stat;
    logic [ADDR_W-1:0] wr_addr;

    // The result register can take a new beat when empty or draining this cycle
    assign out_free   = !r_out_valid || i_m_tready;
    assign res_load   = take && emit;
    assign o_s_tready = !r_in_valid || take;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload: load on every accepted beat, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_data <= i_s_tdata;
            r_in_eos  <= i_s_tlast;
        end
    end

    jdqt_parser #(
        .TABLE_COUNT(TABLE_COUNT)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_valid),
        .i_data     (r_in_data),
        .i_eos      (r_in_eos),
        .i_out_free (out_free),
        .o_take     (take),
        .o_emit     (emit),
        .o_res      (res),
        .o_wr       (wr),
        .o_stat     (stat)
    );

    // Table index selects a 64-entry row; the id is already range-checked
    assign wr_addr = ADDR_W'({wr.table_sel, wr.index});

    jdqt_ram #(
        .WIDTH(jdqt_pkg::VAL_W),
        .DEPTH(DEPTH)
    ) u_table_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr.value),
        .i_rd_addr (wr_addr),
        .o_rd_data ()
    );

    // Result beat valid: set on load, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out.wide_entries, r_out.entry_value, r_out.entry_index,
                         r_out.table_id, r_out.event_res};
    assign o_m_tlast  = r_out.last_in_table;

    // Never overwrite a result beat that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !res_load)
        else $error("result register overwritten while stalled");

    // Once halted, no further result is produced
    a_silent_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.halted |-> !res_load)
        else $error("result produced after halt");

    // Any error result halts the parser
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_load && res.event_res != jdqt_pkg::EV_ENTRY) |=> stat.halted)
        else $error("error reported without halting");

    // Table end marks only the final entry index
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_in_table) |-> (r_out.entry_index == jdqt_pkg::LAST_INDEX))
        else $error("last_in_table on a non-final entry");

endmodule

// File: rtl/jdqt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module jdqt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/jdqt_parser.sv
// Marker/DQT parse state machine: phase registers and per-byte next-state logic.
`timescale 1ns / 1ps

module jdqt_parser #(
    parameter int TABLE_COUNT = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data,
    input  logic              i_eos,
    input  logic              i_out_free,
    output logic              o_take,
    output logic              o_emit,
    output jdqt_pkg::t_result o_res,
    output jdqt_pkg::t_wr     o_wr,
    output jdqt_pkg::t_status o_stat
);

    jdqt_pkg::t_phase r_phase, n_phase;
    logic [15:0]                r_remain, n_remain;
    logic [jdqt_pkg::IDX_W-1:0] r_count, n_count;
    logic [jdqt_pkg::ID_W-1:0]  r_table, n_table;
    logic                       r_wide, n_wide;
    logic [7:0]                 r_hold, n_hold;
    logic                       r_halted, n_halted;

    logic              emit;
    jdqt_pkg::t_result res;
    jdqt_pkg::t_wr     wr;
    logic [15:0]       seg_len;
    logic [15:0]       rem_dec;
    logic [15:0]       need;
    logic              id_bad;
    logic              is_last;
    logic              take;

    assign seg_len = {r_hold, i_data};
    assign rem_dec = r_remain - 16'd1;
    assign need    = (i_data[7:4] != 4'd0) ? jdqt_pkg::NEED_WIDE : jdqt_pkg::NEED_NARROW;
    assign id_bad  = {1'b0, i_data[3:0]} >= 5'(TABLE_COUNT);
    assign is_last = r_count == jdqt_pkg::LAST_INDEX;

    always_comb begin
        n_phase  = r_phase;
        n_remain = r_remain;
        n_count  = r_count;
        n_table  = r_table;
        n_wide   = r_wide;
        n_hold   = r_hold;
        n_halted = r_halted;
        emit     = 1'b0;
        res      = '0;
        wr       = '0;
        if (!r_halted) begin
            if (i_eos) begin
                emit     = 1'b1;
                n_halted = 1'b1;
                res.event_res = (r_phase == jdqt_pkg::PH_SOI0 ||
                                 r_phase == jdqt_pkg::PH_SOI1) ?
                                jdqt_pkg::EV_NO_SOI : jdqt_pkg::EV_EARLY_END;
            end else begin
                case (r_phase)
                    jdqt_pkg::PH_SOI0: begin
                        n_hold  = i_data;
                        n_phase = jdqt_pkg::PH_SOI1;
                    end
                    jdqt_pkg::PH_SOI1: begin
                        if (r_hold != jdqt_pkg::MARKER_PREFIX ||
                            i_data != jdqt_pkg::MARKER_SOI) begin
                            emit          = 1'b1;
                            n_halted      = 1'b1;
                            res.event_res = jdqt_pkg::EV_NO_SOI;
                        end else begin
                            n_phase = jdqt_pkg::PH_MARK0;
                        end
                    end
                    jdqt_pkg::PH_MARK0: begin
                        n_hold  = i_data;
                        n_phase = jdqt_pkg::PH_MARK1;
                    end
                    jdqt_pkg::PH_MARK1: begin
                        if (r_hold != jdqt_pkg::MARKER_PREFIX) begin
                            emit          = 1'b1;
                            n_halted      = 1'b1;
                            res.event_res = jdqt_pkg::EV_NO_MARKER;
                        end else if (i_data == jdqt_pkg::MARKER_DQT) begin
                            n_phase = jdqt_pkg::PH_DQT_LEN_HI;
                        end else if (i_data inside {[jdqt_pkg::MARKER_APP0 :
                                                     jdqt_pkg::MARKER_APP15]}) begin
                            n_phase = jdqt_pkg::PH_APP_LEN_HI;
                        end else begin
                            n_phase = jdqt_pkg::PH_MARK0;
                        end
                    end
                    jdqt_pkg::PH_DQT_LEN_HI: begin
                        n_hold  = i_data;
                        n_phase = jdqt_pkg::PH_DQT_LEN_LO;
                    end
                    jdqt_pkg::PH_APP_LEN_HI: begin
                        n_hold  = i_data;
                        n_phase = jdqt_pkg::PH_APP_LEN_LO;
                    end
                    jdqt_pkg::PH_DQT_LEN_LO, jdqt_pkg::PH_APP_LEN_LO: begin
                        if (seg_len < jdqt_pkg::LEN_HEADER) begin
                            emit          = 1'b1;
                            n_halted      = 1'b1;
                            res.event_res = jdqt_pkg::EV_BAD_LEN;
                        end else begin
                            n_remain = seg_len - jdqt_pkg::LEN_HEADER;
                            if (seg_len == jdqt_pkg::LEN_HEADER) begin
                                n_phase = jdqt_pkg::PH_MARK0;
                            end else if (r_phase == jdqt_pkg::PH_DQT_LEN_LO) begin
                                n_phase = jdqt_pkg::PH_DQT_INFO;
                            end else begin
                                n_phase = jdqt_pkg::PH_APP_SKIP;
                            end
                        end
                    end
                    jdqt_pkg::PH_DQT_INFO: begin
                        n_remain = rem_dec;
                        if (id_bad) begin
                            emit          = 1'b1;
                            n_halted      = 1'b1;
                            res.event_res = jdqt_pkg::EV_BAD_ID;
                        end else if (rem_dec < need) begin
                            emit          = 1'b1;
                            n_halted      = 1'b1;
                            res.event_res = jdqt_pkg::EV_BAD_LEN;
                        end else begin
                            n_remain = rem_dec - need;
                            n_table  = i_data[3:0];
                            n_wide   = i_data[7:4] != 4'd0;
                            n_count  = '0;
                            n_phase  = (i_data[7:4] != 4'd0) ? jdqt_pkg::PH_ENTRY_HI :
                                                               jdqt_pkg::PH_ENTRY_LO;
                        end
                    end
                    jdqt_pkg::PH_ENTRY_HI: begin
                        n_hold  = i_data;
                        n_phase = jdqt_pkg::PH_ENTRY_LO;
                    end
                    jdqt_pkg::PH_ENTRY_LO: begin
                        emit              = 1'b1;
                        wr.en             = 1'b1;
                        wr.table_sel      = r_table;
                        wr.index          = r_count;
                        wr.value          = r_wide ? {r_hold, i_data} : {8'd0, i_data};
                        res.event_res     = jdqt_pkg::EV_ENTRY;
                        res.table_id      = r_table[1:0];
                        res.entry_index   = r_count;
                        res.entry_value   = wr.value;
                        res.wide_entries  = r_wide;
                        res.last_in_table = is_last;
                        if (is_last) begin
                            n_count = '0;
                            n_phase = (r_remain == 16'd0) ? jdqt_pkg::PH_MARK0 :
                                                            jdqt_pkg::PH_DQT_INFO;
                        end else begin
                            n_count = r_count + 1'b1;
                            n_phase = r_wide ? jdqt_pkg::PH_ENTRY_HI : jdqt_pkg::PH_ENTRY_LO;
                        end
                    end
                    jdqt_pkg::PH_APP_SKIP: begin
                        n_remain = rem_dec;
                        if (rem_dec == 16'd0) begin
                            n_phase = jdqt_pkg::PH_MARK0;
                        end
                    end
                    default: begin
                        n_phase = jdqt_pkg::PH_MARK0;
                    end
                endcase
            end
        end
    end

    // Consume the held byte unless it has a result and the output is blocked
    assign take = i_valid && (!emit || i_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= jdqt_pkg::PH_SOI0;
            r_remain <= '0;
            r_count  <= '0;
            r_table  <= '0;
            r_wide   <= 1'b0;
            r_hold   <= '0;
            r_halted <= 1'b0;
        end else if (take) begin
            r_phase  <= n_phase;
            r_remain <= n_remain;
            r_count  <= n_count;
            r_table  <= n_table;
            r_wide   <= n_wide;
            r_hold   <= n_hold;
            r_halted <= n_halted;
        end
    end

    assign o_take        = take;
    assign o_emit        = emit;
    assign o_res         = res;
    assign o_wr.en       = wr.en && take;
    assign o_wr.table_sel = wr.table_sel;
    assign o_wr.index    = wr.index;
    assign o_wr.value    = wr.value;
    assign o_stat.halted = r_halted;
    assign o_stat.phase  = r_phase;

endmodule
